// File: rtl/sbrp_pkg.sv
// ----------------------------------------------------------------------------
// sbrp_pkg
// Shared types and constants for the STUN binding response parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sbrp_pkg;

  // Largest packet that is parsed; later bytes are dropped until the last one.
  localparam int MAX_PACKET_BYTES = 1024;
  localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);

  // Positions stay below 1024 + 65536 (bytes plus attribute length); 17 bits suffice.
  localparam int POS_W            = 17;
  localparam int HDR_BYTES        = 20;

  localparam logic [31:0] STUN_COOKIE   = 32'h2112_A442;
  localparam logic [15:0] TYPE_BIND_OK  = 16'h0101;
  localparam logic [15:0] TYPE_BIND_ERR = 16'h0111;
  localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
  localparam logic [15:0] ATTR_MAPPED     = 16'h0001;
  localparam logic [7:0]  FAMILY_IPV4     = 8'h01;
  localparam int          ADDR_VALUE_BYTES = 8;
  localparam int          ATTR_HDR_BYTES   = 4;

  localparam int STATUS_W = 4;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_XOR_OK    = 4'd0,
    ST_MAPPED_OK = 4'd1,
    ST_SHORT     = 4'd2,
    ST_BAD_TYPE  = 4'd3,
    ST_ERROR_RSP = 4'd4,
    ST_COOKIE    = 4'd5,
    ST_TXID      = 4'd6,
    ST_LENGTH    = 4'd7,
    ST_NONE      = 4'd8
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TXID_HIGH = 1'b0,
    REG_TXID_LOW  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_VALUE,
    PH_STOP
  } attr_phase_t;

  typedef struct packed {
    logic        found;
    logic [31:0] addr;
    logic [15:0] port;
  } addr_rec_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] addr;
    logic [15:0] port;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/stun_binding_response_parser_core.sv
// ----------------------------------------------------------------------------
// stun_binding_response_parser_core
// Byte-serial parser for STUN binding responses, IPv4 mapped address only.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle on the input channel, unless
// stalled, and gives one result word when the byte flagged as last is
// accepted: a status code, the external IPv4 address and the UDP port. The
// header checks and the attribute walk are shallow per-byte updates of the
// packet state registers. The result is registered in the output register,
// or in the skid register while the output register holds an untaken word;
// this two-word output stage lets the input keep flowing while a result
// waits, and the input stalls only once both are full. The configuration
// port is always ready; the user writes the expected transaction ID through
// it only while no packet is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module stun_binding_response_parser_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_data_byte,
  input  wire logic                           in_last_byte,
  // Result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [sbrp_pkg::STATUS_W-1:0]       out_status,
  output logic [31:0]                         out_ipv4_address,
  output logic [15:0]                         out_mapped_port,
  // Configuration channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sbrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                    cfg_data
);
  import sbrp_pkg::*;

  // Configuration registers.
  logic [31:0] txid_high_r;
  logic [63:0] txid_low_r;

  // Packet state.
  logic [CNT_W-1:0] byte_count_r,      byte_count_nxt;
  logic [15:0]      header_type_r,     header_type_nxt;
  logic [15:0]      header_length_r,   header_length_nxt;
  logic [1:0]       ok_r,              ok_nxt;         // bit 0 cookie, bit 1 ID
  attr_phase_t      attr_phase_r,      attr_phase_nxt;
  logic [31:0]      attr_type_len_r,   attr_type_len_nxt;
  logic [CNT_W-1:0] attr_index_r,      attr_index_nxt;
  // Only the last seven value bytes matter: family, port and address.
  logic [55:0]      attr_value_r,      attr_value_nxt;
  addr_rec_t        xor_rec_r,         xor_rec_nxt;
  addr_rec_t        plain_rec_r,       plain_rec_nxt;

  // Output stage.
  logic    out_valid_r;
  result_t out_word_r;
  logic    skid_valid_r;
  result_t skid_word_r;

  logic    in_fire;
  logic    out_fire;
  logic    res_push;
  result_t res_word;

  logic [CNT_W-1:0] pos;
  logic [POS_W-1:0] end_pos;
  logic [POS_W-1:0] attr_reach;
  logic [POS_W-1:0] attr_span;
  logic [15:0]      attr_len;
  logic [2:0]       low_idx;
  logic [7:0]       cookie_byte;
  logic [7:0]       txid_hi_byte;
  logic [7:0]       txid_lo_byte;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign res_push  = in_fire && in_last_byte;

  assign out_valid        = out_valid_r;
  assign out_status       = out_word_r.status;
  assign out_ipv4_address = out_word_r.addr;
  assign out_mapped_port  = out_word_r.port;

  // Expected bytes for the cookie and transaction ID at the current position.
  // For positions 4..7 and 8..11 the low two bits give the byte within the
  // word; for 12..19 the offset from 12 gives the byte of the low word.
  assign pos          = byte_count_r;
  assign low_idx      = 3'(pos - CNT_W'(12));
  assign cookie_byte  = 8'(STUN_COOKIE >> {~pos[1:0], 3'b000});
  assign txid_hi_byte = 8'(txid_high_r >> {~pos[1:0], 3'b000});
  assign txid_lo_byte = 8'(txid_low_r >> {~low_idx, 3'b000});
  assign end_pos      = POS_W'(HDR_BYTES) + POS_W'(header_length_r);

  always_comb begin
    byte_count_nxt    = byte_count_r;
    header_type_nxt   = header_type_r;
    header_length_nxt = header_length_r;
    ok_nxt            = ok_r;
    attr_phase_nxt    = attr_phase_r;
    attr_type_len_nxt = attr_type_len_r;
    attr_index_nxt    = attr_index_r;
    attr_value_nxt    = attr_value_r;
    xor_rec_nxt       = xor_rec_r;
    plain_rec_nxt     = plain_rec_r;
    attr_len          = attr_type_len_r[15:0];
    attr_span         = '0;
    attr_reach        = '0;

    if (byte_count_r < CNT_W'(MAX_PACKET_BYTES)) begin
      byte_count_nxt = byte_count_r + CNT_W'(1);
      if (pos < CNT_W'(2)) begin
        header_type_nxt = {header_type_r[7:0], in_data_byte};
      end else if (pos < CNT_W'(4)) begin
        header_length_nxt = {header_length_r[7:0], in_data_byte};
      end else if (pos < CNT_W'(8)) begin
        if (cookie_byte != in_data_byte) ok_nxt[0] = 1'b0;
      end else if (pos < CNT_W'(12)) begin
        if (txid_hi_byte != in_data_byte) ok_nxt[1] = 1'b0;
      end else if (pos < CNT_W'(HDR_BYTES)) begin
        if (txid_lo_byte != in_data_byte) ok_nxt[1] = 1'b0;
      end else if (POS_W'(pos) < end_pos && attr_phase_r != PH_STOP) begin
        if (attr_phase_r == PH_HDR) begin
          attr_type_len_nxt = {attr_type_len_r[23:0], in_data_byte};
          attr_index_nxt    = attr_index_r + CNT_W'(1);
          attr_len          = attr_type_len_nxt[15:0];
          attr_reach        = POS_W'(pos) + POS_W'(1) + POS_W'(attr_len);
          if (attr_index_nxt >= CNT_W'(ATTR_HDR_BYTES)) begin
            attr_index_nxt = '0;
            attr_value_nxt = '0;
            if (attr_reach > end_pos) begin
              attr_phase_nxt = PH_STOP;
            end else if (attr_len != 16'd0) begin
              attr_phase_nxt = PH_VALUE;
            end
          end
        end else begin
          attr_span = (POS_W'(attr_len) + POS_W'(3)) & ~POS_W'(3);
          if (attr_index_r < CNT_W'(ADDR_VALUE_BYTES)) begin
            attr_value_nxt = {attr_value_r[47:0], in_data_byte};
          end
          attr_index_nxt = attr_index_r + CNT_W'(1);
          if (attr_index_nxt == CNT_W'(ADDR_VALUE_BYTES) &&
              attr_len >= 16'(ADDR_VALUE_BYTES) &&
              attr_value_nxt[55:48] == FAMILY_IPV4) begin
            if (attr_type_len_r[31:16] == ATTR_XOR_MAPPED) begin
              xor_rec_nxt.found = 1'b1;
              xor_rec_nxt.addr  = attr_value_nxt[31:0] ^ STUN_COOKIE;
              xor_rec_nxt.port  = attr_value_nxt[47:32] ^ STUN_COOKIE[31:16];
              attr_phase_nxt    = PH_STOP;
            end else if (attr_type_len_r[31:16] == ATTR_MAPPED && !plain_rec_r.found) begin
              plain_rec_nxt.found = 1'b1;
              plain_rec_nxt.addr  = attr_value_nxt[31:0];
              plain_rec_nxt.port  = attr_value_nxt[47:32];
            end
          end
          if (attr_phase_nxt == PH_VALUE && POS_W'(attr_index_nxt) >= attr_span) begin
            attr_phase_nxt    = PH_HDR;
            attr_index_nxt    = '0;
            attr_type_len_nxt = '0;
          end
        end
      end
    end
  end

  // Result for a packet closed by the current byte, from the updated state.
  always_comb begin
    res_word.addr = '0;
    res_word.port = '0;
    if (byte_count_nxt < CNT_W'(HDR_BYTES)) begin
      res_word.status = ST_SHORT;
    end else if (header_type_nxt != TYPE_BIND_OK) begin
      res_word.status = (header_type_nxt == TYPE_BIND_ERR) ? ST_ERROR_RSP : ST_BAD_TYPE;
    end else if (!ok_nxt[0]) begin
      res_word.status = ST_COOKIE;
    end else if (!ok_nxt[1]) begin
      res_word.status = ST_TXID;
    end else if (POS_W'(HDR_BYTES) + POS_W'(header_length_nxt) > POS_W'(byte_count_nxt)) begin
      res_word.status = ST_LENGTH;
    end else if (xor_rec_nxt.found) begin
      res_word.status = ST_XOR_OK;
      res_word.addr   = xor_rec_nxt.addr;
      res_word.port   = xor_rec_nxt.port;
    end else if (plain_rec_nxt.found) begin
      res_word.status = ST_MAPPED_OK;
      res_word.addr   = plain_rec_nxt.addr;
      res_word.port   = plain_rec_nxt.port;
    end else begin
      res_word.status = ST_NONE;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      txid_high_r <= '0;
      txid_low_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TXID_HIGH: txid_high_r <= cfg_data[31:0];
        REG_TXID_LOW:  txid_low_r  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Packet state: updated per accepted byte, cleared after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n || res_push) begin
      byte_count_r    <= '0;
      header_type_r   <= '0;
      header_length_r <= '0;
      ok_r            <= 2'b11;
      attr_phase_r    <= PH_HDR;
      attr_type_len_r <= '0;
      attr_index_r    <= '0;
      attr_value_r    <= '0;
      xor_rec_r       <= '0;
      plain_rec_r     <= '0;
    end else if (in_fire) begin
      byte_count_r    <= byte_count_nxt;
      header_type_r   <= header_type_nxt;
      header_length_r <= header_length_nxt;
      ok_r            <= ok_nxt;
      attr_phase_r    <= attr_phase_nxt;
      attr_type_len_r <= attr_type_len_nxt;
      attr_index_r    <= attr_index_nxt;
      attr_value_r    <= attr_value_nxt;
      xor_rec_r       <= xor_rec_nxt;
      plain_rec_r     <= plain_rec_nxt;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_word_r   <= skid_word_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_push) begin
      if (!out_valid_r || out_fire) begin
        out_word_r  <= res_word;
        out_valid_r <= 1'b1;
      end else begin
        skid_word_r  <= res_word;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbrp_checker.sv
// ----------------------------------------------------------------------------
// sbrp_checker
// Port-level assertions for the STUN binding response parser core.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrp_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           in_last_byte,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [sbrp_pkg::STATUS_W-1:0]  out_status,
  input wire logic [31:0]                    out_ipv4_address,
  input wire logic [15:0]                    out_mapped_port
);
  import sbrp_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_ipv4_address) && $stable(out_mapped_port))
    else $error("result word changed while stalled");

  // Address and port are only reported with a successful status.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_XOR_OK && out_status != ST_MAPPED_OK |->
      out_ipv4_address == 32'd0 && out_mapped_port == 16'd0)
    else $error("address or port set on a failing status");

  // The input stalls only when a result was held up on the previous cycle.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // A result follows the cycle after a last byte is taken into a free stage.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_byte && !out_valid |=> out_valid)
    else $error("no result after the last byte");

endmodule

bind stun_binding_response_parser_core sbrp_checker u_sbrp_checker (.*);

`default_nettype wire
